@@ rtl/core/pra_pkg.sv @@
// Package for the rate-limited PID actuator controller.
// Holds field widths, parameter defaults, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package pra_pkg;

   // Parameter defaults.
   localparam int GAIN_FRAC_BITS = 16;
   localparam int SUM_WIDTH      = 32;

   // Widest integral the datapath supports; the integral product is split in two halves.
   localparam int SUM_MAX_WIDTH  = 48;

   // Field widths.
   localparam int GAIN_W         = 24;
   localparam int ANGLE_W        = 16;
   localparam int CMD_W          = 16;
   localparam int LIMIT_W        = 15;

   // Configuration port.
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_ANGLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STEP      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ANGLE     = 3'd5;

   // Reset values of the limit registers.
   localparam logic [LIMIT_W-1:0] MAX_STEP_RESET  = 15'd32767;
   localparam logic [LIMIT_W-1:0] MAX_ANGLE_RESET = 15'd1280;

endpackage

@@ rtl/core/pid_rate_limited_actuator.sv @@
// Rate-limited, clamped PID controller for a gimbal actuator.
// Single module, five-stage pipeline; depends on pra_pkg.
`timescale 1ns / 1ps

// One request carries one measured pitch-angle sample and yields exactly one
// response: the gimbal command with flags for rate limiting and clamping.
// The pipeline takes a new request every clock cycle unless a response
// stall has backed up to the first stage. The rate is set by the final
// stage, where the rate limiter compares combinationally against the command
// of the previous sample. Stalls on the response side back up stage by
// stage, so empty stages keep filling while a response waits. The three
// gains, target, step limit and angle limit are written through the csr_
// port; the user must write them only while no request is in flight, as the block itself does not enforce it.
module pid_rate_limited_actuator #(
   parameter int GAIN_FRAC_BITS = pra_pkg::GAIN_FRAC_BITS,
   parameter int SUM_WIDTH      = pra_pkg::SUM_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // Configuration write port.
   input  logic                                  csr_we,
   input  logic [pra_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pra_pkg::CSR_DATA_W-1:0]        csr_wdata,

   // Request channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pra_pkg::ANGLE_W-1:0]    req_measured_angle,

   // Response channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pra_pkg::CMD_W-1:0]      rsp_gimbal_command,
   output logic                                  rsp_rate_limited,
   output logic                                  rsp_clamped
);

   localparam int GAIN_W  = pra_pkg::GAIN_W;
   localparam int ANGLE_W = pra_pkg::ANGLE_W;
   localparam int CMD_W   = pra_pkg::CMD_W;
   localparam int LIMIT_W = pra_pkg::LIMIT_W;
   localparam int SMAX_W  = pra_pkg::SUM_MAX_WIDTH;
   localparam int HALF_W  = SMAX_W / 2;
   localparam int DIFF_W  = ANGLE_W + 1;
   localparam int PD_W    = GAIN_W + 1 + DIFF_W;
   localparam int IL_W    = HALF_W + GAIN_W;
   localparam int IH_W    = HALF_W + GAIN_W + 1;
   localparam int TOT_W   = SMAX_W + GAIN_W + 3;
   localparam int LIM_W   = CMD_W + 2;

   // Configuration registers.
   logic [GAIN_W-1:0]         prop_gain_ff;
   logic [GAIN_W-1:0]         integral_gain_ff;
   logic [GAIN_W-1:0]         deriv_gain_ff;
   logic signed [ANGLE_W-1:0] target_angle_ff;
   logic [LIMIT_W-1:0]        max_step_ff;
   logic [LIMIT_W-1:0]        max_angle_ff;

   // Controller state.
   logic signed [SUM_WIDTH-1:0] error_sum_ff;
   logic signed [SUM_WIDTH-1:0] error_sum_in;
   logic signed [ANGLE_W-1:0]   last_angle_ff;
   logic                        have_last_ff;
   logic signed [CMD_W-1:0]     last_command_ff;

   // Stage valid bits and enables.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en, out_en;
   logic req_accept;

   // Stage payloads.
   logic signed [DIFF_W-1:0]    s1_err_ff, s1_diff_ff;
   logic signed [SUM_WIDTH-1:0] s1_sum_ff;
   logic signed [PD_W-1:0]      s2_prop_ff, s2_deriv_ff;
   logic [IL_W-1:0]             s2_int_lo_ff;
   logic signed [IH_W-1:0]      s2_int_hi_ff;
   logic signed [TOT_W-1:0]     s3_total_ff;
   logic signed [CMD_W-1:0]     s4_raw_ff;
   logic signed [CMD_W-1:0]     out_command_ff;
   logic                        out_rate_ff, out_clamp_ff;

   // Stage combinational values.
   logic signed [DIFF_W-1:0]    err_in, diff_in;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [SMAX_W-1:0]    sum_ext;
   logic [HALF_W-1:0]           sum_lo;
   logic signed [HALF_W-1:0]    sum_hi;
   logic signed [GAIN_W:0]      kp_s, ki_s, kd_s;
   logic signed [PD_W-1:0]      prop_in, deriv_in;
   logic [IL_W-1:0]             int_lo_in;
   logic signed [IH_W-1:0]      int_hi_in;
   logic signed [IL_W:0]        int_lo_s;
   logic signed [IH_W+HALF_W-1:0] int_hi_shift;
   logic signed [TOT_W-1:0]     total_in;
   logic signed [TOT_W:0]       neg_total, shifted;
   logic signed [CMD_W-1:0]     raw_in;
   logic signed [DIFF_W-1:0]    delta, step_s;
   logic signed [LIM_W-1:0]     limited, angle_s;
   logic signed [CMD_W-1:0]     command_in;
   logic                        rate_in, clamp_in;

   // Handshake: each stage loads when it is empty or its successor moves on.
   assign out_en     = !out_valid_ff || rsp_ready;
   assign s4_en      = !s4_valid_ff || out_en;
   assign s3_en      = !s3_valid_ff || s4_en;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_ready  = s1_en;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_en) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integral_gain_ff <= '0;
         deriv_gain_ff    <= '0;
         target_angle_ff  <= '0;
         max_step_ff      <= pra_pkg::MAX_STEP_RESET;
         max_angle_ff     <= pra_pkg::MAX_ANGLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pra_pkg::CSR_PROP_GAIN:     prop_gain_ff     <= csr_wdata;
            pra_pkg::CSR_INTEGRAL_GAIN: integral_gain_ff <= csr_wdata;
            pra_pkg::CSR_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata;
            pra_pkg::CSR_TARGET_ANGLE:  target_angle_ff  <= csr_wdata[ANGLE_W-1:0];
            pra_pkg::CSR_MAX_STEP:      max_step_ff      <= csr_wdata[LIMIT_W-1:0];
            pra_pkg::CSR_MAX_ANGLE:     max_angle_ff     <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage 1: error, derivative and the saturating integral.
   always_comb begin
      err_in   = DIFF_W'(req_measured_angle) - DIFF_W'(target_angle_ff);
      diff_in  = have_last_ff ? DIFF_W'(req_measured_angle) - DIFF_W'(last_angle_ff)
                              : '0;
      sum_wide = (SUM_WIDTH + 1)'(error_sum_ff) + (SUM_WIDTH + 1)'(err_in);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         error_sum_in = {sum_wide[SUM_WIDTH], {(SUM_WIDTH - 1){!sum_wide[SUM_WIDTH]}}};
      end else begin
         error_sum_in = sum_wide[SUM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_angle_ff <= '0;
         have_last_ff  <= 1'b0;
      end else if (req_accept) begin
         error_sum_ff  <= error_sum_in;
         last_angle_ff <= req_measured_angle;
         have_last_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_err_ff  <= err_in;
         s1_diff_ff <= diff_in;
         s1_sum_ff  <= error_sum_in;
      end
   end

   // Stage 2: gain products; the integral is split into two 24-bit halves.
   always_comb begin
      kp_s      = {1'b0, prop_gain_ff};
      ki_s      = {1'b0, integral_gain_ff};
      kd_s      = {1'b0, deriv_gain_ff};
      sum_ext   = SMAX_W'(s1_sum_ff);
      sum_lo    = sum_ext[HALF_W-1:0];
      sum_hi    = sum_ext[SMAX_W-1:HALF_W];
      prop_in   = PD_W'(kp_s) * PD_W'(s1_err_ff);
      deriv_in  = PD_W'(kd_s) * PD_W'(s1_diff_ff);
      int_lo_in = IL_W'(sum_lo) * IL_W'(integral_gain_ff);
      int_hi_in = IH_W'(ki_s) * IH_W'(sum_hi);
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_prop_ff   <= prop_in;
         s2_deriv_ff  <= deriv_in;
         s2_int_lo_ff <= int_lo_in;
         s2_int_hi_ff <= int_hi_in;
      end
   end

   // Stage 3: sum of the three terms at full precision.
   always_comb begin
      int_lo_s     = {1'b0, s2_int_lo_ff};
      int_hi_shift = {s2_int_hi_ff, {HALF_W{1'b0}}};
      total_in     = TOT_W'(s2_prop_ff) + TOT_W'(s2_deriv_ff)
                   + TOT_W'(int_hi_shift) + TOT_W'(int_lo_s);
   end

   always_ff @(posedge clock) begin
      if (s3_en && s2_valid_ff) begin
         s3_total_ff <= total_in;
      end
   end

   // Stage 4: negate, scale down with floor rounding and saturate to 16 bits.
   always_comb begin
      neg_total = -((TOT_W + 1)'(s3_total_ff));
      shifted   = neg_total >>> GAIN_FRAC_BITS;
      if (shifted[TOT_W] && !(&shifted[TOT_W:CMD_W-1])) begin
         raw_in = {1'b1, {(CMD_W - 1){1'b0}}};
      end else if (!shifted[TOT_W] && (|shifted[TOT_W:CMD_W-1])) begin
         raw_in = {1'b0, {(CMD_W - 1){1'b1}}};
      end else begin
         raw_in = shifted[CMD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en && s3_valid_ff) begin
         s4_raw_ff <= raw_in;
      end
   end

   // Stage 5: step limit against the previous command, then magnitude clamp.
   always_comb begin
      step_s   = DIFF_W'({1'b0, max_step_ff});
      angle_s  = LIM_W'({1'b0, max_angle_ff});
      delta    = DIFF_W'(s4_raw_ff) - DIFF_W'(last_command_ff);
      rate_in  = 1'b0;
      clamp_in = 1'b0;
      priority if (delta > step_s) begin
         limited = LIM_W'(last_command_ff) + LIM_W'(step_s);
         rate_in = 1'b1;
      end else if (delta < -step_s) begin
         limited = LIM_W'(last_command_ff) - LIM_W'(step_s);
         rate_in = 1'b1;
      end else begin
         limited = LIM_W'(s4_raw_ff);
      end
      priority if (limited > angle_s) begin
         limited  = angle_s;
         clamp_in = 1'b1;
      end else if (limited < -angle_s) begin
         limited  = -angle_s;
         clamp_in = 1'b1;
      end else begin
         clamp_in = 1'b0;
      end
      command_in = limited[CMD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_command_ff <= '0;
      end else if (out_en && s4_valid_ff) begin
         last_command_ff <= command_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s4_valid_ff) begin
         out_command_ff <= command_in;
         out_rate_ff    <= rate_in;
         out_clamp_ff   <= clamp_in;
      end
   end

   // Response ports.
   assign rsp_valid          = out_valid_ff;
   assign rsp_gimbal_command = out_command_ff;
   assign rsp_rate_limited   = out_rate_ff;
   assign rsp_clamped        = out_clamp_ff;

endmodule
